@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the top level of the LCD write sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/clnws_pkg.sv @@
// Types and constants shared by the LCD nibble write sequencer modules.
package clnws_pkg;

   // Request kinds on req_type.
   typedef enum logic [1:0] {
      REQ_COMMAND = 2'd0,
      REQ_DATA    = 2'd1,
      REQ_CURSOR  = 2'd2,
      REQ_NONE    = 2'd3
   } req_kind_type;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_COMMAND_PULSE = 2'd0,
      CSR_COMMAND_GAP   = 2'd1,
      CSR_DATA_PULSE    = 2'd2,
      CSR_BUSY_SETTLE   = 2'd3
   } csr_index_type;

   // Pin phases of one request, in output order.
   typedef enum logic [2:0] {
      PH_HI_EN  = 3'd0,
      PH_HI_GAP = 3'd1,
      PH_LO_EN  = 3'd2,
      PH_LO_GAP = 3'd3,
      PH_POLL   = 3'd4,
      PH_RELEASE = 3'd5
   } phase_type;

   localparam logic [7:0]  CURSOR_ROW0_BASE = 8'h80;
   localparam logic [7:0]  CURSOR_ROW1_BASE = 8'hC0;
   localparam logic [15:0] COMMAND_PULSE_RESET = 16'd10000;
   localparam logic [15:0] COMMAND_GAP_RESET   = 16'd200;
   localparam logic [15:0] DATA_PULSE_RESET    = 16'd0;
   localparam logic [15:0] BUSY_SETTLE_RESET   = 16'd100;

   // Queue between front and back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] byte_value;
      logic [1:0] row;
      logic [4:0] column;
   } req_item_type;

   typedef struct packed {
      logic        reg_select;
      logic        read_write;
      logic        enable_pin;
      logic [3:0]  nibble;
      logic [15:0] hold_ticks;
      logic        wait_busy;
      logic        status;
      logic        last;
   } rsp_item_type;

   // Classified request as it waits in the queue.
   typedef struct packed {
      logic       is_data;
      logic       reject;
      logic [7:0] byte_value;
   } cmd_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   typedef struct packed {
      logic [15:0] command_pulse_ticks;
      logic [15:0] command_gap_ticks;
      logic [15:0] data_pulse_ticks;
      logic [15:0] busy_settle_ticks;
   } cfg_regs_type;

endpackage

@@ rtl/core/clnws_front.sv @@
// Front stage: accepts requests, resolves cursor positions and checks range.
module clnws_front #(
   parameter int LINE_COLUMNS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  clnws_pkg::req_item_type req_item,
   input  clnws_pkg::queue_stat_type q_stat,
   output logic                    push,
   output clnws_pkg::cmd_entry_type push_entry
);
   import clnws_pkg::*;

   localparam logic [5:0] COLS = 6'(LINE_COLUMNS);

   logic          fr_valid_ff, fr_valid_in;
   cmd_entry_type fr_entry_ff, fr_entry_in;
   logic          accept;
   logic          cursor_bad;
   logic [7:0]    cursor_byte;

   // Handshake: the held item moves on whenever the queue has room
   assign push      = fr_valid_ff && !q_stat.full;
   assign req_stall = fr_valid_ff && q_stat.full;
   assign accept    = req_valid && !req_stall;

   // Classify the incoming item
   always_comb begin
      cursor_bad  = (req_item.row > 2'd1) || ({1'b0, req_item.column} >= COLS);
      cursor_byte = ((req_item.row == 2'd0) ? CURSOR_ROW0_BASE : CURSOR_ROW1_BASE)
                    + {3'b000, req_item.column};
      fr_entry_in = fr_entry_ff;
      fr_valid_in = fr_valid_ff;
      if (accept) begin
         fr_valid_in = (req_item.req_type != REQ_NONE);
         case (req_kind_type'(req_item.req_type))
            REQ_DATA: begin
               fr_entry_in.is_data    = 1'b1;
               fr_entry_in.reject     = 1'b0;
               fr_entry_in.byte_value = req_item.byte_value;
            end
            REQ_CURSOR: begin
               fr_entry_in.is_data    = 1'b0;
               fr_entry_in.reject     = cursor_bad;
               fr_entry_in.byte_value = cursor_byte;
            end
            default: begin
               fr_entry_in.is_data    = 1'b0;
               fr_entry_in.reject     = 1'b0;
               fr_entry_in.byte_value = req_item.byte_value;
            end
         endcase
      end else if (push) begin
         fr_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fr_valid_ff <= 1'b0;
      end else begin
         fr_valid_ff <= fr_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fr_entry_ff <= fr_entry_in;
   end

   assign push_entry = fr_entry_ff;

endmodule

@@ rtl/core/clnws_queue.sv @@
// Small FIFO of classified requests between the front and the back.
module clnws_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  clnws_pkg::cmd_entry_type  push_entry,
   input  logic                      pop,
   output clnws_pkg::cmd_entry_type  head,
   output clnws_pkg::queue_stat_type q_stat
);
   import clnws_pkg::*;

   cmd_entry_type            q_mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                     do_push, do_pop;

   assign q_stat.full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign q_stat.empty = (count_ff == '0);
   assign do_push      = push && !q_stat.full;
   assign do_pop       = pop && !q_stat.empty;
   assign head         = q_mem_ff[rd_ptr_ff];

   // Pointer and count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         q_mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ rtl/core/clnws_back.sv @@
// Back stage: walks the six pin phases of the head request into the output register.
module clnws_back (
   input  logic                      clock,
   input  logic                      reset,
   input  clnws_pkg::cmd_entry_type  head,
   input  clnws_pkg::queue_stat_type q_stat,
   output logic                      pop,
   input  clnws_pkg::cfg_regs_type   cfg,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output clnws_pkg::rsp_item_type   rsp_item
);
   import clnws_pkg::*;

   phase_type    phase_ff, phase_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff, rsp_item_in;
   rsp_item_type ph_item;
   logic         load, fire;
   logic [15:0]  pulse, gap;

   // Output register frees up when empty or being taken
   assign load = !rsp_valid_ff || !rsp_stall;
   assign fire = load && !q_stat.empty;

   // Phase decode and next phase
   always_comb begin
      pulse   = head.is_data ? cfg.data_pulse_ticks : cfg.command_pulse_ticks;
      gap     = head.is_data ? 16'd0 : cfg.command_gap_ticks;
      ph_item = '0;
      ph_item.reg_select = head.is_data;
      phase_in = phase_ff;
      case (phase_ff)
         PH_HI_EN: begin
            ph_item.enable_pin = 1'b1;
            ph_item.nibble     = head.byte_value[7:4];
            ph_item.hold_ticks = pulse;
            phase_in           = PH_HI_GAP;
         end
         PH_HI_GAP: begin
            ph_item.nibble     = head.byte_value[7:4];
            ph_item.hold_ticks = gap;
            phase_in           = PH_LO_EN;
         end
         PH_LO_EN: begin
            ph_item.enable_pin = 1'b1;
            ph_item.nibble     = head.byte_value[3:0];
            ph_item.hold_ticks = pulse;
            phase_in           = PH_LO_GAP;
         end
         PH_LO_GAP: begin
            ph_item.nibble = head.byte_value[3:0];
            phase_in       = PH_POLL;
         end
         PH_POLL: begin
            ph_item.reg_select = 1'b0;
            ph_item.read_write = 1'b1;
            ph_item.enable_pin = 1'b1;
            ph_item.wait_busy  = 1'b1;
            phase_in           = PH_RELEASE;
         end
         PH_RELEASE: begin
            ph_item.reg_select = 1'b0;
            ph_item.hold_ticks = cfg.busy_settle_ticks;
            ph_item.last       = 1'b1;
            phase_in           = PH_HI_EN;
         end
         default: begin
            phase_in = PH_HI_EN;
         end
      endcase
      // rejected cursor position: one status-only item
      if (head.reject) begin
         ph_item        = '0;
         ph_item.status = 1'b1;
         ph_item.last   = 1'b1;
         phase_in       = PH_HI_EN;
      end
      if (!fire) begin
         phase_in = phase_ff;
      end
   end

   assign pop = fire && ph_item.last;

   // Output register control
   always_comb begin
      rsp_valid_in = load ? !q_stat.empty : rsp_valid_ff;
      rsp_item_in  = fire ? ph_item : rsp_item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HI_EN;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

@@ rtl/core/char_lcd_nibble_write_sequencer.sv @@
// Top level of the 4-bit character LCD write sequencer.
// Each request becomes six pin phases (high nibble strobe, gap, low nibble
// strobe, gap, busy poll, release), one phase per clock while the receiver
// does not stall; a rejected cursor position becomes a single status item and
// type 3 produces nothing. The front takes one request per clock, unless the
// four-entry queue is full, so a new request is taken while earlier ones are
// still being sent. The back sequencer emits at most one phase per clock.
// A request passes the front register and the queue before its first phase
// enters the output register. Configuration writes are registered; csr_ready
// is always high.
module char_lcd_nibble_write_sequencer #(
   parameter int LINE_COLUMNS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  clnws_pkg::req_item_type req_item,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output clnws_pkg::rsp_item_type rsp_item,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [1:0]              csr_index,
   input  logic [15:0]             csr_wdata
);
   import clnws_pkg::*;

`include "assert_macros.svh"

   cfg_regs_type   cfg_ff, cfg_in;
   queue_stat_type q_stat;
   cmd_entry_type  push_entry, head;
   logic           push, pop;

   assign csr_ready = 1'b1;

   // Configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_COMMAND_PULSE: cfg_in.command_pulse_ticks = csr_wdata;
            CSR_COMMAND_GAP:   cfg_in.command_gap_ticks   = csr_wdata;
            CSR_DATA_PULSE:    cfg_in.data_pulse_ticks    = csr_wdata;
            CSR_BUSY_SETTLE:   cfg_in.busy_settle_ticks   = csr_wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.command_pulse_ticks <= COMMAND_PULSE_RESET;
         cfg_ff.command_gap_ticks   <= COMMAND_GAP_RESET;
         cfg_ff.data_pulse_ticks    <= DATA_PULSE_RESET;
         cfg_ff.busy_settle_ticks   <= BUSY_SETTLE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   clnws_front #(
      .LINE_COLUMNS(LINE_COLUMNS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .q_stat     (q_stat),
      .push       (push),
      .push_entry (push_entry)
   );

   clnws_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .q_stat     (q_stat)
   );

   clnws_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .q_stat    (q_stat),
      .pop       (pop),
      .cfg       (cfg_ff),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   // A taken phase that is not the last one is followed at once by the next
   `ASSERT_NEXT(a_phase_run, clock, reset, rsp_valid && !rsp_stall && !rsp_item.last, rsp_valid, "phase run broken")
   // Nothing appears at the output without a queued request
   `ASSERT_NEXT(a_no_invent, clock, reset, q_stat.empty && !rsp_valid, !rsp_valid, "item without request")
   // A command pulse write lands in its register
   `ASSERT_NEXT(a_csr_write, clock, reset, csr_valid && csr_ready && (csr_index == CSR_COMMAND_PULSE), cfg_ff.command_pulse_ticks == $past(csr_wdata), "csr write lost")

endmodule

@@ tb/char_lcd_phase_checker.sv @@
// Checker for the LCD nibble write sequencer: predicts pin phases and compares them.
module char_lcd_phase_checker #(
   parameter int LINE_COLUMNS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_stall,
   input  clnws_pkg::req_item_type req_item,
   input  logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  clnws_pkg::rsp_item_type rsp_item,
   input  logic                    csr_valid,
   input  logic                    csr_ready,
   input  logic [1:0]              csr_index,
   input  logic [15:0]             csr_wdata,
   output int                      fail_count,
   output int                      pending_phases
);
   timeunit 1ns;
   timeprecision 1ps;
   import clnws_pkg::*;

   // Shadow copy of the timing registers
   cfg_regs_type ticks;
   // Phases still owed by the block, oldest first
   rsp_item_type expected_phases[$];
   int           mismatches = 0;

   initial begin
      fail_count     = 0;
      pending_phases = 0;
   end

   function automatic rsp_item_type make_phase(logic rs, logic rw, logic en,
                                               logic [3:0] nib, logic [15:0] hold,
                                               logic wb, logic st, logic lst);
      rsp_item_type ph;
      ph.reg_select = rs;
      ph.read_write = rw;
      ph.enable_pin = en;
      ph.nibble     = nib;
      ph.hold_ticks = hold;
      ph.wait_busy  = wb;
      ph.status     = st;
      ph.last       = lst;
      return ph;
   endfunction

   // Expand one request into its pin phases
   function automatic void predict_phases(req_item_type req);
      logic [7:0]  code;
      logic        rs;
      logic [15:0] pulse;
      logic [15:0] gap;
      code = req.byte_value;
      case (req_kind_type'(req.req_type))
         REQ_NONE: begin
            return;
         end
         REQ_CURSOR: begin
            // out-of-range row or column: single status item
            if (req.row > 2'd1 || req.column >= LINE_COLUMNS) begin
               expected_phases.push_back(make_phase(0, 0, 0, 4'h0, 16'h0, 0, 1, 1));
               return;
            end
            code = (req.row == 2'd0 ? CURSOR_ROW0_BASE : CURSOR_ROW1_BASE)
                   + {3'b000, req.column};
         end
         default: ;
      endcase
      if (req_kind_type'(req.req_type) == REQ_DATA) begin
         rs    = 1'b1;
         pulse = ticks.data_pulse_ticks;
         gap   = 16'h0;
      end else begin
         rs    = 1'b0;
         pulse = ticks.command_pulse_ticks;
         gap   = ticks.command_gap_ticks;
      end
      expected_phases.push_back(make_phase(rs, 0, 1, code[7:4], pulse, 0, 0, 0));
      expected_phases.push_back(make_phase(rs, 0, 0, code[7:4], gap, 0, 0, 0));
      expected_phases.push_back(make_phase(rs, 0, 1, code[3:0], pulse, 0, 0, 0));
      expected_phases.push_back(make_phase(rs, 0, 0, code[3:0], 16'h0, 0, 0, 0));
      expected_phases.push_back(make_phase(0, 1, 1, 4'h0, 16'h0, 1, 0, 0));
      expected_phases.push_back(make_phase(0, 0, 0, 4'h0, ticks.busy_settle_ticks,
                                           0, 0, 1));
   endfunction

   function automatic bit field_ok(string name, logic [15:0] want, logic [15:0] got);
      if (got === want)
         return 1'b1;
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      return 1'b0;
   endfunction

   function automatic void check_phase(rsp_item_type want, rsp_item_type got);
      bit ok;
      ok = 1'b1;
      ok = field_ok("reg_select", want.reg_select, got.reg_select) & ok;
      ok = field_ok("read_write", want.read_write, got.read_write) & ok;
      ok = field_ok("enable_pin", want.enable_pin, got.enable_pin) & ok;
      ok = field_ok("nibble", want.nibble, got.nibble) & ok;
      ok = field_ok("hold_ticks", want.hold_ticks, got.hold_ticks) & ok;
      ok = field_ok("wait_busy", want.wait_busy, got.wait_busy) & ok;
      ok = field_ok("status", want.status, got.status) & ok;
      ok = field_ok("last", want.last, got.last) & ok;
      if (!ok)
         mismatches++;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         ticks.command_pulse_ticks = COMMAND_PULSE_RESET;
         ticks.command_gap_ticks   = COMMAND_GAP_RESET;
         ticks.data_pulse_ticks    = DATA_PULSE_RESET;
         ticks.busy_settle_ticks   = BUSY_SETTLE_RESET;
         expected_phases.delete();
      end else begin
         // register writes
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_COMMAND_PULSE: ticks.command_pulse_ticks = csr_wdata;
               CSR_COMMAND_GAP:   ticks.command_gap_ticks   = csr_wdata;
               CSR_DATA_PULSE:    ticks.data_pulse_ticks    = csr_wdata;
               CSR_BUSY_SETTLE:   ticks.busy_settle_ticks   = csr_wdata;
               default: ;
            endcase
         end
         // results out
         if (rsp_valid && !rsp_stall) begin
            if (expected_phases.size() == 0) begin
               $display("%0t: unexpected item, expected none got %0h", $time, rsp_item);
               mismatches++;
            end else begin
               check_phase(expected_phases.pop_front(), rsp_item);
            end
         end
         // requests in
         if (req_valid && !req_stall)
            predict_phases(req_item);
      end
      fail_count     <= mismatches;
      pending_phases <= expected_phases.size();
   end

endmodule

@@ tb/tb_char_lcd_nibble_write_sequencer.sv @@
// Testbench top for the LCD nibble write sequencer: clock, reset, stimulus and verdict.
module tb_char_lcd_nibble_write_sequencer;
   timeunit 1ns;
   timeprecision 1ps;
   import clnws_pkg::*;

   localparam int LINE_COLUMNS  = 16;
   localparam int RANDOM_ITEMS  = 470;
   localparam int SEGMENTS      = 6;
   localparam int SETTLE_CYCLES = 16;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_item  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_item;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [1:0]   csr_index = '0;
   logic [15:0]  csr_wdata = '0;
   int           fail_count;
   int           pending_phases;
   int           send_idle_pct = 0;
   int           stall_pct     = 0;

   always #5 clock = ~clock;

   char_lcd_nibble_write_sequencer #(
      .LINE_COLUMNS(LINE_COLUMNS)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   char_lcd_phase_checker #(
      .LINE_COLUMNS(LINE_COLUMNS)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_item       (req_item),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_item       (rsp_item),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .fail_count     (fail_count),
      .pending_phases (pending_phases)
   );

   // Receiver back-pressure
   always @(negedge clock) begin
      rsp_stall = ($urandom_range(0, 99) < stall_pct);
   end

   // Present one request, with random idle cycles ahead of it
   task automatic send_request(input req_item_type item);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_item  = item;
      do @(posedge clock); while (req_stall);
   endtask

   // Hold off until every owed phase is out and the block has gone quiet
   task automatic wait_drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_phases != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [15:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic req_item_type make_req(req_kind_type kind, logic [7:0] code,
                                             logic [1:0] row, logic [4:0] column);
      req_item_type item;
      item.req_type   = kind;
      item.byte_value = code;
      item.row        = row;
      item.column     = column;
      return item;
   endfunction

   // Mostly well-formed commands, data and positions; some bad positions and type 3
   function automatic req_item_type random_request();
      int unsigned  pick;
      req_item_type item;
      pick            = $urandom_range(0, 99);
      item.byte_value = 8'($urandom);
      item.row        = 2'($urandom);
      item.column     = 5'($urandom);
      if (pick < 10) begin
         item.req_type = REQ_NONE;
      end else if (pick < 40) begin
         item.req_type = REQ_COMMAND;
      end else if (pick < 70) begin
         item.req_type = REQ_DATA;
      end else begin
         item.req_type = REQ_CURSOR;
         if (pick < 92) begin
            item.row    = 2'($urandom_range(0, 1));
            item.column = 5'($urandom_range(0, LINE_COLUMNS - 1));
         end
      end
      return item;
   endfunction

   initial begin
      req_item_type directed[$];
      cfg_regs_type settings[SEGMENTS];
      req_item_type item;
      int           sent;

      settings[0] = '0;
      settings[1] = '1;
      settings[2] = {16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
      settings[3] = {16'h0001, 16'h8000, 16'h7FFF, 16'hFFFE};
      settings[4] = {16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
      settings[5] = {COMMAND_PULSE_RESET, COMMAND_GAP_RESET, DATA_PULSE_RESET,
                     BUSY_SETTLE_RESET};

      // Directed: byte extremes, every request kind, edges of the cursor window
      directed.push_back(make_req(REQ_COMMAND, 8'h00, 2'd0, 5'd0));
      directed.push_back(make_req(REQ_COMMAND, 8'hFF, 2'd3, 5'd31));
      directed.push_back(make_req(REQ_COMMAND, 8'h01, 2'd0, 5'd0));
      directed.push_back(make_req(REQ_COMMAND, 8'hA5, 2'd1, 5'd10));
      directed.push_back(make_req(REQ_DATA, 8'h00, 2'd0, 5'd0));
      directed.push_back(make_req(REQ_DATA, 8'hFF, 2'd3, 5'd31));
      directed.push_back(make_req(REQ_DATA, 8'h5A, 2'd2, 5'd21));
      directed.push_back(make_req(REQ_CURSOR, 8'hFF, 2'd0, 5'd0));
      directed.push_back(make_req(REQ_CURSOR, 8'h00, 2'd0, 5'd15));
      directed.push_back(make_req(REQ_CURSOR, 8'h00, 2'd1, 5'd0));
      directed.push_back(make_req(REQ_CURSOR, 8'h00, 2'd1, 5'd15));
      // rejected positions: bad row, bad column, both bad
      directed.push_back(make_req(REQ_CURSOR, 8'h00, 2'd2, 5'd0));
      directed.push_back(make_req(REQ_CURSOR, 8'h00, 2'd0, 5'd16));
      directed.push_back(make_req(REQ_CURSOR, 8'h00, 2'd1, 5'd31));
      directed.push_back(make_req(REQ_CURSOR, 8'hFF, 2'd3, 5'd31));
      directed.push_back(make_req(REQ_CURSOR, 8'h00, 2'd3, 5'd5));
      // type 3 is dropped without output
      directed.push_back(make_req(REQ_NONE, 8'h00, 2'd0, 5'd0));
      directed.push_back(make_req(REQ_NONE, 8'hFF, 2'd3, 5'd31));
      directed.push_back(make_req(REQ_COMMAND, 8'h80, 2'd0, 5'd0));

      repeat (9) @(negedge clock);
      reset = 1'b0;

      // Directed part runs on the reset register values
      send_idle_pct = 13;
      stall_pct     = 49;
      foreach (directed[i])
         send_request(directed[i]);

      // Random segments: idling mode changes every two segments
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         wait_drain();
         case (seg / 2)
            0: begin
               send_idle_pct = 13;
               stall_pct     = 49;
            end
            1: begin
               send_idle_pct = 49;
               stall_pct     = 13;
            end
            default: begin
               send_idle_pct = 0;
               stall_pct     = 0;
            end
         endcase
         write_csr(CSR_COMMAND_PULSE, settings[seg].command_pulse_ticks);
         write_csr(CSR_COMMAND_GAP, settings[seg].command_gap_ticks);
         write_csr(CSR_DATA_PULSE, settings[seg].data_pulse_ticks);
         write_csr(CSR_BUSY_SETTLE, settings[seg].busy_settle_ticks);
         sent = 0;
         while (sent < RANDOM_ITEMS / SEGMENTS) begin
            // now and then let the pipeline run dry
            if ($urandom_range(0, 59) == 0)
               wait_drain();
            item = random_request();
            send_request(item);
            sent++;
         end
      end

      wait_drain();
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
